// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on clk with synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, ignored while in reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that an antecedent leads to a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
  `ASSERT_CLK(lbl, (ante) |=> (cons))

`endif

// ===== hdl/skxg_pkg.sv =====
// ----------------------------------------------------------------------------
// Seed key generator package
// Widths, round constants, mask table and sequencer states.
// ----------------------------------------------------------------------------
package skxg_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 7;

  localparam logic [CountW-1:0] RoundBase = 7'h1F;

  typedef logic [WordW-1:0] word_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Mask word chosen by the 4-bit selector.
  function automatic word_t mix_word(input logic [3:0] sel);
    word_t w;
    case (sel)
      4'd0:    w = 32'h14FA3579;
      4'd1:    w = 32'h27CD3964;
      4'd2:    w = 32'h1777FE32;
      4'd3:    w = 32'h9931AF12;
      4'd4:    w = 32'h75DB3A49;
      4'd5:    w = 32'h19294CAA;
      4'd6:    w = 32'hFF18CD76;
      4'd7:    w = 32'h0788236D;
      4'd8:    w = 32'h5A6F7CBB;
      4'd9:    w = 32'h7A992254;
      4'd10:   w = 32'hADFD5414;
      4'd11:   w = 32'h343CFBCB;
      4'd12:   w = 32'hC2F51639;
      4'd13:   w = 32'h6A6D5813;
      4'd14:   w = 32'h3729FF68;
      4'd15:   w = 32'h22A2C751;
      default: w = '0;
    endcase
    return w;
  endfunction

  // Round count: base plus six scattered seed bits (weight 32 never set).
  function automatic count_t round_count(input word_t s);
    count_t c;
    c = {s[0], 1'b0, s[9], s[1], s[11], s[2], s[5]};
    return c + RoundBase;
  endfunction

  function automatic logic [3:0] mask_sel(input word_t s);
    return {s[0], s[1], s[2], s[9]};
  endfunction

endpackage

// ===== hdl/seed_key_shift_xor_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Seed key shift-xor generator
// Turns a 32-bit access seed into a 32-bit key over 31 to 126 rounds.
// ----------------------------------------------------------------------------
// Usage:
//   Present a seed on in_seed_word with in_valid; it is taken when in_ready is
//   high. The key appears on out_key_word with out_valid and holds until
//   out_ready takes it.
//   One request runs through a single shift-xor round unit, one round per
//   cycle unless its last round is held for the output register. The round
//   count is 31 plus six seed bits; the seed is first loaded, then the key
//   comes out of the last round. in_ready is low while the rounds run, so a
//   new seed is taken only once the running request is back in idle.
//   The finished key sits in an output register, so the next seed is taken
//   while a key still waits. If the receiver stalls that long, the running
//   request holds before its last round until the output register frees up.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending key.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module seed_key_shift_xor_generator_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  skxg_pkg::word_t in_seed_word,
  output logic            out_valid,
  input  logic            out_ready,
  output skxg_pkg::word_t out_key_word
);
  import skxg_pkg::*;

  state_t state_r, state_nxt;
  count_t cnt_r, cnt_nxt;
  word_t  word_r, word_nxt;
  word_t  mask_r, mask_nxt;
  word_t  key_r, key_nxt;
  logic   out_valid_r, out_valid_nxt;
  word_t  round_out;
  logic   last_round;
  logic   advance;

  skxg_round u_round (
    .word_i (word_r),
    .mask_i (mask_r),
    .word_o (round_out)
  );

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_key_word = key_r;

  assign last_round = (cnt_r == count_t'(1));
  // Hold the last round while the previous key is still unclaimed.
  assign advance    = !(last_round && out_valid_r && !out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    word_nxt      = word_r;
    mask_nxt      = mask_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_seed_word;
          mask_nxt  = mix_word(mask_sel(in_seed_word));
          cnt_nxt   = round_count(in_seed_word);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (advance) begin
          word_nxt = round_out;
          cnt_nxt  = cnt_r - count_t'(1);
          if (last_round) begin
            key_nxt       = round_out;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    mask_r <= mask_nxt;
    key_r  <= key_nxt;
  end

  `ASSERT_CLK(a_run_cnt_nonzero, (state_r == ST_RUN) |-> (cnt_r != '0))
  `ASSERT_NEXT(a_accept_starts_run, in_valid && in_ready, state_r == ST_RUN)
  `ASSERT_CLK(a_key_from_last_round,
    $rose(out_valid_r) |-> $past(state_r == ST_RUN && cnt_r == count_t'(1)))

endmodule

// ===== hdl/skxg_round.sv =====
// ----------------------------------------------------------------------------
// Seed key round unit
// One shift-left round; fold in the mask when the dropped top bit was set.
// ----------------------------------------------------------------------------
module skxg_round (
  input  skxg_pkg::word_t word_i,
  input  skxg_pkg::word_t mask_i,
  output skxg_pkg::word_t word_o
);
  import skxg_pkg::*;

  word_t shifted;

  assign shifted = {word_i[WordW-2:0], 1'b0};
  assign word_o  = word_i[WordW-1] ? (shifted ^ mask_i) : shifted;

endmodule
